// ----- hdl/ahdt_pkg.sv -----
// ----------------------------------------------------------------------------
// ahdt_pkg
// Shared widths, operation codes, result codes and register indexes of the
// ARP host discovery table.
// ----------------------------------------------------------------------------
`default_nettype none

package ahdt_pkg;

    localparam int AHDT_TABLE_DEPTH = 256;

    localparam int OP_W    = 2;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int OPC_W   = 16;
    localparam int ACT_W   = 3;
    localparam int INDEX_W = 8;
    localparam int TOTAL_W = 9;
    localparam int STEP_W  = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [ACT_W-1:0]     t_action;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    // Item operations.
    localparam t_op OP_PACKET = 2'd0;
    localparam t_op OP_TICK   = 2'd1;
    localparam t_op OP_START  = 2'd2;

    // Result actions.
    localparam t_action ACT_NONE    = 3'd0;
    localparam t_action ACT_REQUEST = 3'd1;
    localparam t_action ACT_STORED  = 3'd2;
    localparam t_action ACT_FULL    = 3'd3;
    localparam t_action ACT_DONE    = 3'd4;

    // Configuration register indexes.
    localparam t_cfg_index CFG_LOCAL_IP  = 1'b0;
    localparam t_cfg_index CFG_LOCAL_MAC = 1'b1;

    localparam logic [OPC_W-1:0] ARP_OPC_REPLY = 16'h0002;

    // Scan step that follows the last address of the sweep.
    localparam logic [STEP_W-1:0] SCAN_LAST_STEP = 9'd255;

endpackage

`default_nettype wire

// ----- hdl/ahdt_if.sv -----
// ----------------------------------------------------------------------------
// ahdt_if
// Valid/ready channels of the ARP host discovery table: item input, result
// output and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ahdt_req_if;
    logic                           valid;
    logic                           ready;
    logic [ahdt_pkg::OP_W-1:0]      op;
    logic [ahdt_pkg::IP_W-1:0]      sender_ip;
    logic [ahdt_pkg::MAC_W-1:0]     sender_mac;
    logic [ahdt_pkg::IP_W-1:0]      target_ip_in;
    logic [ahdt_pkg::MAC_W-1:0]     target_mac_in;
    logic [ahdt_pkg::OPC_W-1:0]     arp_opcode;

    modport source (output valid, op, sender_ip, sender_mac, target_ip_in,
                     target_mac_in, arp_opcode, input ready);
    modport sink   (input valid, op, sender_ip, sender_mac, target_ip_in,
                     target_mac_in, arp_opcode, output ready);
endinterface

interface ahdt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ahdt_pkg::ACT_W-1:0]     action;
    logic [ahdt_pkg::IP_W-1:0]      request_ip;
    logic [ahdt_pkg::MAC_W-1:0]     host_mac;
    logic [ahdt_pkg::INDEX_W-1:0]   host_index;
    logic [ahdt_pkg::TOTAL_W-1:0]   host_total;

    modport source (output valid, action, request_ip, host_mac, host_index,
                     host_total, input ready);
    modport sink   (input valid, action, request_ip, host_mac, host_index,
                     host_total, output ready);
endinterface

interface ahdt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ahdt_pkg::CFG_IDX_W-1:0]     reg_index;
    logic [ahdt_pkg::CFG_DATA_W-1:0]    wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ----- hdl/arp_host_discovery_table.sv -----
// ----------------------------------------------------------------------------
// arp_host_discovery_table
// Snoops ARP traffic, keeps a table of hosts on the local /24 and drives
// subnet sweeps one address per scan tick.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  i_req     in         op, sender/target IP and MAC, ARP opcode
//  o_rsp     out        action, request_ip, host_mac, host_index, host_total
//  i_cfg     in         register writes: local_ip, local_mac (always ready)
//
//  A received packet from the local subnet runs a search of the host IP
//  memory, which is read one entry a cycle and ends early when the sender
//  is found, so its length grows with the host count. Ticks, start commands
//  and foreign packets skip the search. One item is worked at a time; the
//  next request is taken while the previous result still waits in the
//  output register. Reset needs no clearing pass: only entries below the
//  host count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_host_discovery_table #(
    parameter int TABLE_DEPTH = ahdt_pkg::AHDT_TABLE_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    ahdt_req_if.sink      i_req,
    ahdt_rsp_if.source    o_rsp,
    ahdt_cfg_if.sink      i_cfg
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]                         r_state;

    logic [ahdt_pkg::IP_W-1:0]          r_local_ip;
    logic [ahdt_pkg::MAC_W-1:0]         r_local_mac;

    ahdt_pkg::t_op                      r_op;
    logic [ahdt_pkg::IP_W-1:0]          r_sip;
    logic [ahdt_pkg::MAC_W-1:0]         r_smac;
    logic [ahdt_pkg::IP_W-1:0]          r_tip;
    logic [ahdt_pkg::MAC_W-1:0]         r_tmac;
    logic [ahdt_pkg::OPC_W-1:0]         r_opc;
    logic                               r_is_reply;

    logic [CW-1:0]                      r_host_count;
    logic                               r_scan_active;
    logic [ahdt_pkg::STEP_W-1:0]        r_scan_step;
    logic [ahdt_pkg::STEP_W-1:0]        n_scan_step;
    logic [ahdt_pkg::IP_W-1:0]          scan_addr;

    logic [ahdt_pkg::IP_W-1:0]          r_ip_mem [TABLE_DEPTH];
    logic [ahdt_pkg::IP_W-1:0]          r_rd_ip;
    logic [CW-1:0]                      r_issue;
    logic                               r_cmp_vld;

    ahdt_pkg::t_action                  r_res_action;
    logic [ahdt_pkg::IP_W-1:0]          r_res_ip;
    logic [ahdt_pkg::MAC_W-1:0]         r_res_mac;
    logic [ahdt_pkg::INDEX_W-1:0]       r_res_index;

    logic                               r_out_valid;
    ahdt_pkg::t_action                  r_out_action;
    logic [ahdt_pkg::IP_W-1:0]          r_out_ip;
    logic [ahdt_pkg::MAC_W-1:0]         r_out_mac;
    logic [ahdt_pkg::INDEX_W-1:0]       r_out_index;
    logic [ahdt_pkg::TOTAL_W-1:0]       r_out_total;

    logic                               in_accept;
    logic                               cfg_accept;
    logic                               issue_go;
    logic                               hit;
    logic                               search_end;
    logic                               full;
    logic                               mem_we;
    logic                               mem_re;
    logic [AW+ahdt_pkg::INDEX_W-1:0]    index_ext;
    logic [CW+ahdt_pkg::TOTAL_W-1:0]    total_ext;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_accept   = i_req.valid && i_req.ready;
    assign cfg_accept  = i_cfg.valid && i_cfg.ready;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.action     = r_out_action;
    assign o_rsp.request_ip = r_out_ip;
    assign o_rsp.host_mac   = r_out_mac;
    assign o_rsp.host_index = r_out_index;
    assign o_rsp.host_total = r_out_total;

    // The search issues one read per cycle and compares the entry returned in the
    // cycle after; it ends on a match or once every held entry is checked.
    assign issue_go   = (r_issue != r_host_count);
    assign hit        = r_cmp_vld && (r_rd_ip == r_sip);
    assign search_end = hit || (!issue_go && !r_cmp_vld);
    assign full       = (r_host_count == DEPTH_C);
    assign mem_re     = (r_state == S_SEARCH) && issue_go;
    assign mem_we     = (r_state == S_SEARCH) && search_end && !hit && r_is_reply
                        && !full;

    assign n_scan_step = r_scan_step + 1'b1;
    assign scan_addr   = {r_local_ip[ahdt_pkg::IP_W-1:8], n_scan_step[7:0]};

    assign index_ext = {{ahdt_pkg::INDEX_W{1'b0}}, r_host_count[AW-1:0]};
    assign total_ext = {{ahdt_pkg::TOTAL_W{1'b0}}, r_host_count};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ip_mem[r_host_count[AW-1:0]] <= r_sip;
        end
        if (mem_re) begin
            r_rd_ip <= r_ip_mem[r_issue[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_local_ip    <= '0;
            r_local_mac   <= '0;
            r_host_count  <= '0;
            r_scan_active <= 1'b1;
            r_scan_step   <= '0;
            r_cmp_vld     <= 1'b0;
            r_issue       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_accept) begin
                case (i_cfg.reg_index)
                    ahdt_pkg::CFG_LOCAL_IP: begin
                        r_local_ip <= i_cfg.wdata[ahdt_pkg::IP_W-1:0];
                    end
                    ahdt_pkg::CFG_LOCAL_MAC: begin
                        r_local_mac <= i_cfg.wdata[ahdt_pkg::MAC_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_op    <= i_req.op;
                        r_sip   <= i_req.sender_ip;
                        r_smac  <= i_req.sender_mac;
                        r_tip   <= i_req.target_ip_in;
                        r_tmac  <= i_req.target_mac_in;
                        r_opc   <= i_req.arp_opcode;
                        r_state <= S_EVAL;
                    end
                end

                S_EVAL: begin
                    r_res_action <= ahdt_pkg::ACT_NONE;
                    r_res_ip     <= '0;
                    r_res_mac    <= '0;
                    r_res_index  <= '0;
                    r_state      <= S_EMIT;
                    case (r_op)
                        ahdt_pkg::OP_PACKET: begin
                            if (r_sip[ahdt_pkg::IP_W-1:8]
                                    == r_local_ip[ahdt_pkg::IP_W-1:8]) begin
                                r_is_reply <= (r_opc == ahdt_pkg::ARP_OPC_REPLY)
                                              && (r_tip == r_local_ip)
                                              && (r_tmac == r_local_mac);
                                r_issue    <= '0;
                                r_cmp_vld  <= 1'b0;
                                r_state    <= S_SEARCH;
                            end
                        end
                        ahdt_pkg::OP_TICK: begin
                            if (r_scan_active) begin
                                // The first tick of a sweep empties the table.
                                if (r_scan_step == '0) begin
                                    r_host_count <= '0;
                                end
                                r_scan_step <= n_scan_step;
                                if (n_scan_step < ahdt_pkg::SCAN_LAST_STEP
                                        && scan_addr != r_local_ip) begin
                                    r_res_action <= ahdt_pkg::ACT_REQUEST;
                                    r_res_ip     <= scan_addr;
                                end else if (n_scan_step > ahdt_pkg::SCAN_LAST_STEP) begin
                                    r_scan_active <= 1'b0;
                                    r_res_action  <= ahdt_pkg::ACT_DONE;
                                end
                            end
                        end
                        ahdt_pkg::OP_START: begin
                            r_scan_active <= 1'b1;
                            r_scan_step   <= '0;
                        end
                        default: begin
                        end
                    endcase
                end

                S_SEARCH: begin
                    r_cmp_vld <= issue_go;
                    if (issue_go) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (search_end) begin
                        r_state <= S_EMIT;
                        if (r_is_reply) begin
                            if (!hit && full) begin
                                r_res_action <= ahdt_pkg::ACT_FULL;
                                r_res_ip     <= r_sip;
                                r_res_mac    <= r_smac;
                            end else if (!hit) begin
                                r_res_action <= ahdt_pkg::ACT_STORED;
                                r_res_ip     <= r_sip;
                                r_res_mac    <= r_smac;
                                r_res_index  <= index_ext[ahdt_pkg::INDEX_W-1:0];
                                r_host_count <= r_host_count + 1'b1;
                            end
                        end else if (!hit && r_sip != r_local_ip) begin
                            r_res_action <= ahdt_pkg::ACT_REQUEST;
                            r_res_ip     <= r_sip;
                        end
                    end
                end

                S_EMIT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_action <= r_res_action;
                        r_out_ip     <= r_res_ip;
                        r_out_mac    <= r_res_mac;
                        r_out_index  <= r_res_index;
                        r_out_total  <= total_ext[ahdt_pkg::TOTAL_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_host_count <= DEPTH_C)
        else $error("host count exceeds table depth");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_issue <= r_host_count))
        else $error("search reads beyond the held entries");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_host_count != '0) && (r_res_action == ahdt_pkg::ACT_STORED))
        else $error("table write without a stored result");

endmodule

`default_nettype wire

// ----- sim/ahdt_monitor.sv -----
// ----------------------------------------------------------------------------
// ahdt_monitor
// Watches the request, result and register channels of the ARP host
// discovery table, keeps its own copy of the host table and sweep state,
// and compares every result with the action that the accepted request
// should cause.
// ----------------------------------------------------------------------------
module ahdt_monitor (
    input  wire  i_clk,
    input  wire  i_rst_n,
    ahdt_req_if  i_req,
    ahdt_rsp_if  i_rsp,
    ahdt_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending
);
    import ahdt_pkg::*;

    typedef struct packed {
        t_action              action;
        logic [IP_W-1:0]      request_ip;
        logic [MAC_W-1:0]     host_mac;
        logic [INDEX_W-1:0]   host_index;
        logic [TOTAL_W-1:0]   host_total;
    } t_host_action;

    logic [IP_W-1:0]    my_ip;
    logic [MAC_W-1:0]   my_mac;
    logic [IP_W-1:0]    known_ip  [AHDT_TABLE_DEPTH];
    logic [MAC_W-1:0]   known_mac [AHDT_TABLE_DEPTH];
    int                 known_cnt;
    logic               sweep_on;
    logic [STEP_W-1:0]  sweep_step;
    logic [7:0]         sweep_octet;
    t_host_action       actions_due[$];
    int                 errors;

    function automatic bit is_known(logic [IP_W-1:0] ip);
        for (int i = 0; i < known_cnt; i++) begin
            if (known_ip[i] == ip) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one request to the local copy of the table and returns the
    // action that it should produce.
    function automatic t_host_action arp_table_step(t_op op, logic [IP_W-1:0] sip,
            logic [MAC_W-1:0] smac, logic [IP_W-1:0] tip, logic [MAC_W-1:0] tmac,
            logic [OPC_W-1:0] opc);
        t_host_action act;
        logic [IP_W-1:0] addr;
        act = '0;
        if (op == OP_PACKET) begin
            // Senders outside our /24 are ignored altogether.
            if (sip[IP_W-1:8] == my_ip[IP_W-1:8]) begin
                if (opc == ARP_OPC_REPLY && tip == my_ip && tmac == my_mac) begin
                    if (!is_known(sip)) begin
                        act.request_ip = sip;
                        act.host_mac   = smac;
                        if (known_cnt >= AHDT_TABLE_DEPTH) begin
                            act.action = ACT_FULL;
                        end else begin
                            known_ip[known_cnt]  = sip;
                            known_mac[known_cnt] = smac;
                            act.action     = ACT_STORED;
                            act.host_index = INDEX_W'(known_cnt);
                            known_cnt++;
                        end
                    end
                end else if (!is_known(sip) && sip != my_ip) begin
                    act.action     = ACT_REQUEST;
                    act.request_ip = sip;
                end
            end
        end else if (op == OP_TICK && sweep_on) begin
            if (sweep_step == '0) begin
                known_cnt   = 0;
                sweep_octet = '0;
            end
            sweep_step  = sweep_step + 1'b1;
            sweep_octet = sweep_octet + 1'b1;
            addr = {my_ip[IP_W-1:8], sweep_octet};
            if (sweep_step < SCAN_LAST_STEP && addr != my_ip) begin
                act.action     = ACT_REQUEST;
                act.request_ip = addr;
            end else if (sweep_step > SCAN_LAST_STEP) begin
                sweep_on   = 1'b0;
                act.action = ACT_DONE;
            end
        end else if (op == OP_START) begin
            sweep_on    = 1'b1;
            sweep_step  = '0;
            sweep_octet = '0;
        end
        act.host_total = TOTAL_W'(known_cnt);
        return act;
    endfunction

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_host_action seen;
        t_host_action want;
        if (!i_rst_n) begin
            my_ip       = '0;
            my_mac      = '0;
            known_cnt   = 0;
            sweep_on    = 1'b1;
            sweep_step  = '0;
            sweep_octet = '0;
            errors      = 0;
            actions_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    CFG_LOCAL_IP:  my_ip  = i_cfg.wdata[IP_W-1:0];
                    CFG_LOCAL_MAC: my_mac = i_cfg.wdata[MAC_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                actions_due.push_back(arp_table_step(i_req.op, i_req.sender_ip,
                    i_req.sender_mac, i_req.target_ip_in, i_req.target_mac_in,
                    i_req.arp_opcode));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                seen = {i_rsp.action, i_rsp.request_ip, i_rsp.host_mac,
                        i_rsp.host_index, i_rsp.host_total};
                if (actions_due.size() == 0) begin
                    $display("%0t: result with no request waiting, expected none, got 0x%0h",
                             $time, seen);
                    errors++;
                end else begin
                    want = actions_due.pop_front();
                    check_field("action", 64'(want.action), 64'(seen.action));
                    check_field("request_ip", 64'(want.request_ip), 64'(seen.request_ip));
                    check_field("host_mac", 64'(want.host_mac), 64'(seen.host_mac));
                    check_field("host_index", 64'(want.host_index), 64'(seen.host_index));
                    check_field("host_total", 64'(want.host_total), 64'(seen.host_total));
                end
            end
        end
        o_errors  <= errors;
        o_pending <= actions_due.size();
    end

endmodule

// ----- sim/arp_host_discovery_table_test.sv -----
// ----------------------------------------------------------------------------
// arp_host_discovery_table_test
// Drives the ARP host discovery table through directed packets and sweeps,
// a full subnet sweep, a fill of the whole host table, overflow on a new
// subnet and random traffic, with sender gaps and receiver stalls in turn.
// ----------------------------------------------------------------------------
module arp_host_discovery_table_test;
    import ahdt_pkg::*;

    localparam t_op               OP_UNUSED       = 2'd3;
    localparam logic [OPC_W-1:0]  ARP_OPC_REQUEST = 16'h0001;
    localparam int                SWEEP_TICKS     = 256;
    localparam int                DRAIN_CYCLES    = AHDT_TABLE_DEPTH + 16;

    typedef struct packed {
        t_op                op;
        logic [IP_W-1:0]    sender_ip;
        logic [MAC_W-1:0]   sender_mac;
        logic [IP_W-1:0]    target_ip_in;
        logic [MAC_W-1:0]   target_mac_in;
        logic [OPC_W-1:0]   arp_opcode;
    } t_arp_req;

    logic               i_clk;
    logic               i_rst_n;
    int                 fail_count;
    int                 awaiting;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    logic [IP_W-1:0]    my_ip;
    logic [MAC_W-1:0]   my_mac;

    ahdt_req_if req_ch ();
    ahdt_rsp_if rsp_ch ();
    ahdt_cfg_if cfg_ch ();

    arp_host_discovery_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    ahdt_monitor monitor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (fail_count),
        .o_pending (awaiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic t_arp_req rand_item(t_op op);
        t_arp_req it;
        it.op            = op;
        it.sender_ip     = $urandom;
        it.sender_mac    = rand_mac();
        it.target_ip_in  = $urandom;
        it.target_mac_in = rand_mac();
        it.arp_opcode    = 16'($urandom);
        return it;
    endfunction

    // A reply from a host on our subnet, addressed to us.
    function automatic t_arp_req host_reply(logic [7:0] octet, logic [MAC_W-1:0] mac);
        t_arp_req it;
        it = rand_item(OP_PACKET);
        it.sender_ip     = {my_ip[IP_W-1:8], octet};
        it.sender_mac    = mac;
        it.target_ip_in  = my_ip;
        it.target_mac_in = my_mac;
        it.arp_opcode    = ARP_OPC_REPLY;
        return it;
    endfunction

    function automatic t_arp_req local_packet(logic [7:0] octet, logic [OPC_W-1:0] opc);
        t_arp_req it;
        it = rand_item(OP_PACKET);
        it.sender_ip  = {my_ip[IP_W-1:8], octet};
        it.arp_opcode = opc;
        return it;
    endfunction

    function automatic t_arp_req pick_item(int tick_pct, bit start_ok);
        t_arp_req it;
        int roll;
        int k;
        it = rand_item(OP_TICK);
        if ($urandom_range(99) >= tick_pct) begin
            roll = $urandom_range(99);
            if (roll < 50) begin
                it = host_reply(8'($urandom_range(255)), rand_mac());
            end else if (roll < 65) begin
                it = local_packet(8'($urandom_range(255)), 16'($urandom));
            end else if (roll < 78) begin
                // Looks like a reply to us but misses our address by one bit.
                it = host_reply(8'($urandom_range(255)), rand_mac());
                if ($urandom_range(1) == 1) begin
                    k = $urandom_range(IP_W-1);
                    it.target_ip_in[k] = ~it.target_ip_in[k];
                end else begin
                    k = $urandom_range(MAC_W-1);
                    it.target_mac_in[k] = ~it.target_mac_in[k];
                end
            end else if (roll < 90) begin
                it = rand_item(OP_PACKET);
                if (it.sender_ip[IP_W-1:8] == my_ip[IP_W-1:8]) begin
                    k = 8 + $urandom_range(IP_W-9);
                    it.sender_ip[k] = ~it.sender_ip[k];
                end
            end else begin
                it = rand_item(t_op'($urandom_range(3)));
                if (it.op == OP_START && !start_ok) it.op = OP_UNUSED;
            end
        end
        return it;
    endfunction

    // The valid line is lowered only when a gap follows, so back-to-back
    // requests never see two assignments in one step.
    task automatic send_req(t_arp_req it);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= it.op;
        req_ch.sender_ip     <= it.sender_ip;
        req_ch.sender_mac    <= it.sender_mac;
        req_ch.target_ip_in  <= it.target_ip_in;
        req_ch.target_mac_in <= it.target_mac_in;
        req_ch.arp_opcode    <= it.arp_opcode;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (awaiting != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
        settle();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= CFG_LOCAL_IP;
        cfg_ch.wdata     <= CFG_DATA_W'(ip);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.reg_index <= CFG_LOCAL_MAC;
        cfg_ch.wdata     <= mac;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        my_ip  = ip;
        my_mac = mac;
    endtask

    initial begin
        t_arp_req   it;
        int         ticks;
        int         j;
        logic [7:0] octets [AHDT_TABLE_DEPTH];
        logic [7:0] swap;

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        my_ip          = '0;
        my_mac         = '0;
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.op            <= OP_PACKET;
        req_ch.sender_ip     <= '0;
        req_ch.sender_mac    <= '0;
        req_ch.target_ip_in  <= '0;
        req_ch.target_mac_in <= '0;
        req_ch.arp_opcode    <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.reg_index     <= CFG_LOCAL_IP;
        cfg_ch.wdata         <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed traffic on 192.168.1.0/24, the own host at .100.
        program_regs(32'hC0A8_0164, rand_mac());
        it = '1;
        send_req(it);
        it = '0;
        send_req(it);
        send_req(rand_item(OP_TICK));
        send_req(rand_item(OP_TICK));
        send_req(rand_item(OP_START));
        send_req(rand_item(OP_TICK));
        send_req(host_reply(8'd7, '1));
        send_req(host_reply(8'd7, rand_mac()));
        it = local_packet(8'd7, ARP_OPC_REQUEST);
        it.target_ip_in  = my_ip;
        it.target_mac_in = my_mac;
        send_req(it);
        send_req(local_packet(my_ip[7:0], ARP_OPC_REQUEST));
        send_req(local_packet(8'd9, ARP_OPC_REQUEST));
        it = host_reply(8'd20, rand_mac());
        it.target_mac_in = ~my_mac;
        send_req(it);
        it = host_reply(8'd21, rand_mac());
        it.target_ip_in = {my_ip[IP_W-1:1], ~my_ip[0]};
        send_req(it);
        send_req(host_reply(my_ip[7:0], rand_mac()));
        send_req(host_reply(8'h00, '0));
        send_req(host_reply(8'hFF, rand_mac()));
        it = rand_item(OP_PACKET);
        it.sender_ip = '1;
        send_req(it);
        send_req(local_packet(8'd30, 16'hFFFF));
        it = host_reply(8'd40, rand_mac());
        it.arp_opcode = {8'h01, ARP_OPC_REPLY[7:0]};
        send_req(it);
        send_req(rand_item(OP_TICK));

        // A complete sweep with packets mixed in, sender mostly idle.
        settle();
        send_idle_pct = 75;
        send_req(rand_item(OP_START));
        ticks = 0;
        while (ticks < SWEEP_TICKS) begin
            if ($urandom_range(99) < 3) begin
                send_req(pick_item(0, 1'b0));
            end else begin
                send_req(rand_item(OP_TICK));
                ticks++;
            end
        end

        // Every address of the subnet replies once, so the table ends full.
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        for (int i = 0; i < AHDT_TABLE_DEPTH; i++) octets[i] = 8'(i);
        for (int i = AHDT_TABLE_DEPTH - 1; i > 0; i--) begin
            j = $urandom_range(i);
            swap      = octets[i];
            octets[i] = octets[j];
            octets[j] = swap;
        end
        for (int i = 0; i < AHDT_TABLE_DEPTH; i++) begin
            send_req(host_reply(octets[i], rand_mac()));
            if ($urandom_range(99) < 3) send_req(pick_item(10, 1'b0));
        end

        // New subnet while the table is full: fresh hosts overflow.
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        program_regs('1, '1);
        send_req(host_reply(8'($urandom_range(255)), rand_mac()));
        repeat (12) send_req(pick_item(15, 1'b1));

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_regs('0, '0);
        repeat (12) send_req(pick_item(20, 1'b1));

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && awaiting == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
